>>> rtl/wts_pkg.sv
// Shared types and constants for the weighted table sampler.
// No dependencies; imported by wts_cell and weighted_table_sampler.
package wts_pkg;

  localparam int MAX_MODES_DEF = 8;
  localparam int MAX_MODES_LIM = 64;
  localparam int FRAC_BITS     = 16;
  localparam int RAND_W        = 16;
  localparam int RATIO_W       = 17;
  localparam int BODY_W        = 3;
  localparam int IDX_W         = 3;
  localparam int WEIGHT_W      = 20;
  // room for a full table of maximal ratios
  localparam int PREF_W        = RATIO_W + $clog2(MAX_MODES_LIM);
  localparam int PROD_W        = PREF_W + RAND_W;

  localparam logic [PREF_W-1:0] ONE_VAL =
    {{(PREF_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [BODY_W-1:0] BODY_MIN = BODY_W'(2);
  localparam logic [BODY_W-1:0] BODY_MAX = BODY_W'(3);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_FIN = 2'd1,
    CMD_SMP = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FINAL = 3'd1,
    ST_FULL  = 3'd2,
    ST_BODY  = 3'd3,
    ST_NOFIN = 3'd4,
    ST_SUM   = 3'd5
  } st_t;

  typedef enum logic [1:0] {
    OP_INS  = 2'd0,
    OP_SUM  = 2'd1,
    OP_PICK = 2'd2
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } fsm_t;

  // token handed from cell to cell, one hop per cycle
  typedef struct packed {
    logic                go;
    op_t                 op;
    logic                have;   // insert: entry still looking for its place
    logic [RATIO_W-1:0]  prob;
    logic [IDX_W-1:0]    idx;
    logic [PREF_W-1:0]   acc;    // running prefix sum
    logic [PROD_W-1:0]   x;      // scaled random value
    logic                found;
    logic [IDX_W-1:0]    sel;
    logic [IDX_W-1:0]    last;
  } tok_t;

endpackage

>>> rtl/wts_cell.sv
// One table slot of the sampler chain: holds an entry in sorted position.
// Depends on wts_pkg (tok_t, op_t, widths).
module wts_cell import wts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic occ,
  input  tok_t tin,
  output tok_t tout
);

  logic [RATIO_W-1:0] prob, prob_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [PREF_W-1:0]  prefix, prefix_next;
  tok_t               tnext;

  always_comb begin
    tnext       = tin;
    prob_next   = prob;
    idx_next    = idx;
    prefix_next = prefix;
    if (tin.go && occ) begin
      unique case (tin.op)
        OP_INS: begin
          // strictly greater only, so equal weights keep arrival order
          if (tin.have && tin.prob > prob) begin
            prob_next  = tin.prob;
            idx_next   = tin.idx;
            tnext.prob = prob;
            tnext.idx  = idx;
          end
        end
        OP_SUM: begin
          prefix_next = tin.acc + PREF_W'(prob);
          tnext.acc   = prefix_next;
        end
        OP_PICK: begin
          tnext.last = idx;
          if (!tin.found && tin.x < {prefix, {RAND_W{1'b0}}}) begin
            tnext.found = 1'b1;
            tnext.sel   = idx;
          end
        end
        default: ;
      endcase
    end else if (tin.go && tin.op == OP_INS && tin.have) begin
      // first free slot takes whatever entry reaches it
      prob_next  = tin.prob;
      idx_next   = tin.idx;
      tnext.have = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prob   <= prob_next;
    idx    <= idx_next;
    prefix <= prefix_next;
  end

  always_ff @(posedge clk) begin
    if (rst) tout <= '0;
    else     tout <= tnext;
  end

endmodule

>>> rtl/weighted_table_sampler.sv
// Weighted table sampler: command decode, result register and a chain of slots.
// Depends on wts_pkg and wts_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  request | req_valid/req_ready  | cmd, ratio, daughter_count, random_value,
//          |                      | weighted
//  result  | rsp_valid/rsp_ready  | status, mode_valid, mode_index, total_weight
//
// Commands that only check state give their result in the cycle after the transfer.
// Add, finalise and sample that touch the table send a token down the slot chain,
// one slot a cycle; the result is registered once the token leaves the last slot.
// A new request is taken only in idle and when the result register is free or
// being emptied in the same cycle. Synchronous reset empties the table.
module weighted_table_sampler import wts_pkg::*; #(
  parameter int MAX_MODES = MAX_MODES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [1:0]          cmd,
  input  logic [RATIO_W-1:0]  ratio,
  input  logic [BODY_W-1:0]   daughter_count,
  input  logic [RAND_W-1:0]   random_value,
  input  logic                weighted,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [2:0]          status,
  output logic                mode_valid,
  output logic [IDX_W-1:0]    mode_index,
  output logic [WEIGHT_W-1:0] total_weight
);

  localparam int CNT_W = $clog2(MAX_MODES + 1);

  fsm_t                state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                table_final, table_final_next;
  logic                body_bad, body_bad_next;
  logic [PREF_W-1:0]   total, total_next;
  logic                wmode, wmode_next;
  tok_t                head, head_next;
  logic                rsp_valid_next;
  st_t                 status_next;
  logic                mode_valid_next;
  logic [IDX_W-1:0]    mode_index_next;
  logic [WEIGHT_W-1:0] total_weight_next;
  logic                take;
  logic [PREF_W-1:0]   scale;
  tok_t                tail;

  tok_t                link [MAX_MODES+1];
  logic [MAX_MODES-1:0] occ;

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign take      = req_valid && req_ready;
  assign scale     = weighted ? total : ONE_VAL;
  assign link[0]   = head;
  assign tail      = link[MAX_MODES];

  for (genvar g = 0; g < MAX_MODES; g++) begin : g_slot
    assign occ[g] = count > CNT_W'(g);
    wts_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .occ  (occ[g]),
      .tin  (link[g]),
      .tout (link[g+1])
    );
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    table_final_next  = table_final;
    body_bad_next     = body_bad;
    total_next        = total;
    wmode_next        = wmode;
    head_next         = head;
    head_next.go      = 1'b0;
    rsp_valid_next    = rsp_valid && !rsp_ready;
    status_next       = st_t'(status);
    mode_valid_next   = mode_valid;
    mode_index_next   = mode_index;
    total_weight_next = total_weight;

    unique case (state)
      S_IDLE: begin
        if (take) begin
          rsp_valid_next    = 1'b1;
          status_next       = ST_OK;
          mode_valid_next   = 1'b0;
          mode_index_next   = '0;
          total_weight_next = '0;
          head_next.have    = 1'b0;
          head_next.prob    = ratio;
          head_next.idx     = IDX_W'(count);
          head_next.acc     = '0;
          head_next.x       = PROD_W'(scale) * PROD_W'(random_value);
          head_next.found   = 1'b0;
          head_next.sel     = '0;
          head_next.last    = '0;
          unique case (cmd_t'(cmd))
            CMD_ADD: begin
              if (table_final) begin
                status_next = ST_FINAL;
              end else if (count >= CNT_W'(MAX_MODES)) begin
                status_next = ST_FULL;
              end else begin
                body_bad_next  = body_bad || daughter_count < BODY_MIN ||
                                 daughter_count > BODY_MAX;
                head_next.go   = 1'b1;
                head_next.op   = OP_INS;
                head_next.have = 1'b1;
                rsp_valid_next = 1'b0;
                state_next     = S_RUN;
              end
            end
            CMD_FIN: begin
              if (table_final) begin
                status_next = ST_FINAL;
              end else if (body_bad) begin
                status_next = ST_BODY;
              end else if (count != '0) begin
                head_next.go   = 1'b1;
                head_next.op   = OP_SUM;
                rsp_valid_next = 1'b0;
                state_next     = S_RUN;
              end
            end
            CMD_SMP: begin
              if (count == '0) begin
                total_weight_next = weighted ? WEIGHT_W'(ONE_VAL) : '0;
              end else if (!table_final) begin
                status_next = ST_NOFIN;
              end else if (!weighted && total > ONE_VAL) begin
                status_next = ST_SUM;
              end else begin
                wmode_next     = weighted;
                head_next.go   = 1'b1;
                head_next.op   = OP_PICK;
                rsp_valid_next = 1'b0;
                state_next     = S_RUN;
              end
            end
            CMD_NOP: ;
          endcase
        end
      end
      S_RUN: begin
        if (tail.go) begin
          state_next        = S_IDLE;
          rsp_valid_next    = 1'b1;
          status_next       = ST_OK;
          mode_valid_next   = 1'b0;
          mode_index_next   = '0;
          total_weight_next = '0;
          unique case (tail.op)
            OP_INS: count_next = count + CNT_W'(1);
            OP_SUM: begin
              total_next       = tail.acc;
              table_final_next = 1'b1;
            end
            OP_PICK: begin
              if (wmode) begin
                // weighted mode falls back to the last slot
                mode_valid_next   = 1'b1;
                mode_index_next   = tail.found ? tail.sel : tail.last;
                total_weight_next = total[WEIGHT_W-1:0];
              end else begin
                mode_valid_next = tail.found;
                mode_index_next = tail.found ? tail.sel : '0;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      table_final <= 1'b0;
      body_bad    <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      table_final <= table_final_next;
      body_bad    <= body_bad_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    total        <= total_next;
    wmode        <= wmode_next;
    status       <= status_next;
    mode_valid   <= mode_valid_next;
    mode_index   <= mode_index_next;
    total_weight <= total_weight_next;
  end

  always_ff @(posedge clk) begin
    if (rst) head <= '0;
    else     head <= head_next;
  end

endmodule

>>> dv/weighted_table_sampler_tb.sv
// Self-checking testbench for weighted_table_sampler: table building, finalise and sampling.
// Needs wts_pkg and the RTL only. A built-in predictor scores every result transfer in order.
`timescale 1ns / 100ps

module weighted_table_sampler_tb;
  import wts_pkg::*;

  localparam longint unsigned UNITY = 64'd1 << FRAC_BITS;
  localparam int DEPTH = MAX_MODES_DEF;
  localparam int RATIO_MAX = (1 << RATIO_W) - 1;

  typedef struct {
    cmd_t                cmd;
    logic [RATIO_W-1:0]  ratio;
    logic [BODY_W-1:0]   bodies;
    logic [RAND_W-1:0]   rand_val;
    logic                weighted;
  } req_t;

  typedef struct {
    st_t                 status;
    logic                hit;
    logic [IDX_W-1:0]    index;
    logic [WEIGHT_W-1:0] weight;
  } reply_t;

  typedef enum {SHAPE_UNIT, SHAPE_UNDER, SHAPE_OVER, SHAPE_BADBODY} shape_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  logic [1:0]          cmd = CMD_NOP;
  logic [RATIO_W-1:0]  ratio = '0;
  logic [BODY_W-1:0]   daughter_count = '0;
  logic [RAND_W-1:0]   random_value = '0;
  logic                weighted = 1'b0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  logic [2:0]          status;
  logic                mode_valid;
  logic [IDX_W-1:0]    mode_index;
  logic [WEIGHT_W-1:0] total_weight;

  req_t   pending_reqs[$];
  reply_t expected_replies[$];
  logic [RAND_W-1:0] near_vals[$];   // random values either side of a prefix boundary
  req_t   offered;
  int     send_idle_pct = 6;
  int     recv_idle_pct = 65;
  int     hold_left = 0;
  logic   hold_trig = 1'b0;
  int     fail_count = 0;

  // predictor copy of the table
  logic [RATIO_W-1:0] tbl_prob   [DEPTH] = '{default: '0};
  logic [BODY_W-1:0]  tbl_body   [DEPTH] = '{default: '0};
  logic [IDX_W-1:0]   tbl_order  [DEPTH] = '{default: '0};
  longint unsigned    tbl_prefix [DEPTH] = '{default: 0};
  int unsigned        tbl_count = 0;
  bit                 tbl_final = 1'b0;

  weighted_table_sampler dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .cmd            (cmd),
    .ratio          (ratio),
    .daughter_count (daughter_count),
    .random_value   (random_value),
    .weighted       (weighted),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .status         (status),
    .mode_valid     (mode_valid),
    .mode_index     (mode_index),
    .total_weight   (total_weight)
  );

  always #4 clk = ~clk;

  // first sorted entry whose prefix sum lies above scale * r
  function automatic bit first_above(longint unsigned scale, logic [RAND_W-1:0] r,
                                     output logic [IDX_W-1:0] idx);
    longint unsigned x;
    int unsigned i;
    x = scale * longint'(r);
    idx = '0;
    for (i = 0; i < tbl_count; i++) begin
      if (x < (tbl_prefix[i] << RAND_W)) begin
        idx = tbl_order[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic reply_t predict_reply(req_t q);
    reply_t a;
    longint unsigned sum, total;
    int unsigned i, j;
    bit bad;
    a = '{ST_OK, 1'b0, '0, '0};
    case (q.cmd)
      CMD_ADD: begin
        if (tbl_final) a.status = ST_FINAL;
        else if (tbl_count >= DEPTH) a.status = ST_FULL;
        else begin
          tbl_prob[tbl_count] = q.ratio;
          tbl_body[tbl_count] = q.bodies;
          tbl_count++;
        end
      end
      CMD_FIN: begin
        bad = 1'b0;
        for (i = 0; i < tbl_count; i++)
          if (tbl_body[i] < BODY_MIN || tbl_body[i] > BODY_MAX) bad = 1'b1;
        if (tbl_final) a.status = ST_FINAL;
        else if (bad) a.status = ST_BODY;
        else begin
          // stable: equal probabilities keep insertion order
          for (i = 0; i < tbl_count; i++) begin
            j = i;
            while (j > 0 && tbl_prob[tbl_order[j-1]] < tbl_prob[i]) begin
              tbl_order[j] = tbl_order[j-1];
              j--;
            end
            tbl_order[j] = IDX_W'(i);
          end
          sum = 0;
          for (i = 0; i < tbl_count; i++) begin
            sum += tbl_prob[tbl_order[i]];
            tbl_prefix[i] = sum;
          end
          if (tbl_count > 0) tbl_final = 1'b1;
        end
      end
      CMD_SMP: begin
        if (tbl_count == 0) begin
          if (q.weighted) a.weight = WEIGHT_W'(UNITY);
        end else if (!tbl_final) begin
          a.status = ST_NOFIN;
        end else begin
          total = tbl_prefix[tbl_count-1];
          if (!q.weighted) begin
            if (total > UNITY) a.status = ST_SUM;
            else if (tbl_count == 1 && total == UNITY) begin
              a.hit = 1'b1;
              a.index = tbl_order[0];
            end else a.hit = first_above(UNITY, q.rand_val, a.index);
          end else begin
            a.weight = WEIGHT_W'(total);
            a.hit = 1'b1;
            if (tbl_count == 1) a.index = tbl_order[0];
            else if (!first_above(total, q.rand_val, a.index))
              a.index = tbl_order[tbl_count-1];
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic void queue_req(cmd_t c, logic [RATIO_W-1:0] rt, logic [BODY_W-1:0] bd,
                                    logic [RAND_W-1:0] rv, logic w);
    req_t q;
    q = '{c, rt, bd, rv, w};
    pending_reqs = {pending_reqs, q};
  endfunction

  task automatic queue_random(int count);
    int n, u, v;
    logic [RAND_W-1:0] rv;
    for (n = 0; n < count; n++) begin
      u = $urandom_range(99);
      v = $urandom_range(99);
      if (v < 40 && near_vals.size() != 0) rv = near_vals[$urandom_range(near_vals.size()-1)];
      else if (v < 45) rv = '0;
      else if (v < 50) rv = '1;
      else rv = RAND_W'($urandom);
      if (u < 4)
        queue_req(CMD_NOP, RATIO_W'($urandom_range(RATIO_MAX)), BODY_W'($urandom_range(7)),
                  rv, 1'($urandom_range(1)));
      else if (u < 7)
        queue_req(CMD_ADD, RATIO_W'($urandom_range(RATIO_MAX)), BODY_W'($urandom_range(7)),
                  rv, 1'($urandom_range(1)));
      else if (u < 10)
        queue_req(CMD_FIN, RATIO_W'($urandom_range(RATIO_MAX)), BODY_W'($urandom_range(7)),
                  rv, 1'($urandom_range(1)));
      else
        queue_req(CMD_SMP, RATIO_W'($urandom_range(RATIO_MAX)), BODY_W'($urandom_range(7)),
                  rv, 1'($urandom_range(1)));
    end
  endtask

  // request driver
  always @(posedge clk) begin : driver
    req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready)
        expected_replies = {expected_replies, predict_reply(offered)};
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          offered        <= nxt;
          cmd            <= nxt.cmd;
          ratio          <= nxt.ratio;
          daughter_count <= nxt.bodies;
          random_value   <= nxt.rand_val;
          weighted       <= nxt.weighted;
          req_valid      <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted separately from the random stalls
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_trig) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin : monitor
    reply_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result transfer with nothing expected: status %0d", status);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (mode_valid !== want.hit) begin
            $error("mode_valid: expected %0d, got %0d", want.hit, mode_valid);
            fail_count++;
          end
          if (mode_index !== want.index) begin
            $error("mode_index: expected %0d, got %0d", want.index, mode_index);
            fail_count++;
          end
          if (total_weight !== want.weight) begin
            $error("total_weight: expected %0d, got %0d", want.weight, total_weight);
            fail_count++;
          end
        end
      end
      rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    shape_t shape;
    int n, k, u;
    longint unsigned room, p, total, b;
    logic [RATIO_W-1:0] rt, prev;
    logic [BODY_W-1:0] bd;
    int bad_slot;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset is applied once, so each run builds a single table; the seed picks its shape
    u = $urandom_range(99);
    if (u < 10) shape = SHAPE_UNIT;
    else if (u < 55) shape = SHAPE_UNDER;
    else if (u < 80) shape = SHAPE_OVER;
    else shape = SHAPE_BADBODY;
    if (shape == SHAPE_UNIT) n = 1;
    else if ($urandom_range(1)) n = DEPTH;
    else n = $urandom_range(1, DEPTH-1);
    bad_slot = $urandom_range(n-1);

    // empty table
    queue_req(CMD_SMP, '0, '0, '1, 1'b0);
    queue_req(CMD_SMP, '1, '1, '0, 1'b1);
    queue_req(CMD_FIN, '0, '0, '0, 1'b0);
    queue_req(CMD_NOP, '1, '1, '1, 1'b1);

    room = UNITY;
    prev = '0;
    for (k = 0; k < n; k++) begin
      bd = BODY_W'($urandom_range(2, 3));
      case (shape)
        SHAPE_UNIT: rt = RATIO_W'(UNITY);
        SHAPE_UNDER: begin
          u = $urandom_range(99);
          if (k == n-1 && u < 50) rt = RATIO_W'(room);           // total lands on 1.0
          else if (u < 12) rt = '0;
          else if (k > 0 && u < 45 && prev <= room) rt = prev;   // tie
          else rt = RATIO_W'($urandom_range(0, (2 * room) / (n - k) > room ?
                                             room : (2 * room) / (n - k)));
          room -= rt;
        end
        SHAPE_OVER: begin
          if (k == 0) rt = '1;
          else if (k == 1) rt = '0;
          else if ($urandom_range(2) == 0) rt = prev;
          else rt = RATIO_W'($urandom_range(RATIO_MAX));
        end
        default: begin
          rt = RATIO_W'($urandom_range(RATIO_W'(UNITY)));
          if (k == bad_slot) bd = ($urandom_range(1)) ? BODY_W'($urandom_range(1))
                                                      : BODY_W'($urandom_range(4, 7));
        end
      endcase
      queue_req(CMD_ADD, rt, bd, RAND_W'($urandom), 1'($urandom_range(1)));
      prev = rt;
    end

    queue_req(CMD_SMP, '0, '0, RAND_W'($urandom), 1'b0);
    queue_req(CMD_SMP, '0, '0, RAND_W'($urandom), 1'b1);
    if (n == DEPTH) queue_req(CMD_ADD, '1, '1, '0, 1'b0);
    queue_req(CMD_FIN, '0, '0, '0, 1'b0);
    queue_req(CMD_FIN, '1, '1, '1, 1'b1);
    queue_req(CMD_ADD, '0, '0, '0, 1'b0);
    queue_req(CMD_SMP, '0, '0, '0, 1'b0);
    queue_req(CMD_SMP, '0, '0, '1, 1'b0);
    queue_req(CMD_SMP, '0, '0, '0, 1'b1);
    queue_req(CMD_SMP, '0, '0, '1, 1'b1);

    while (pending_reqs.size() != 0 || req_valid || expected_replies.size() != 0)
      @(negedge clk);

    // random values just either side of each selection boundary
    if (tbl_final) begin
      total = tbl_prefix[tbl_count-1];
      for (k = 0; k < tbl_count; k++) begin
        p = tbl_prefix[k];
        if (p >= 1 && p - 1 <= 16'hFFFF) near_vals = {near_vals, RAND_W'(p - 1)};
        if (p <= 16'hFFFF) near_vals = {near_vals, RAND_W'(p)};
        if (total != 0) begin
          b = ((p << RAND_W) + total - 1) / total;
          if (b >= 1 && b - 1 <= 16'hFFFF) near_vals = {near_vals, RAND_W'(b - 1)};
          if (b <= 16'hFFFF) near_vals = {near_vals, RAND_W'(b)};
        end
      end
    end

    queue_random(510);
    while (pending_reqs.size() != 0) @(negedge clk);
    @(posedge clk);
    send_idle_pct <= 65;
    recv_idle_pct <= 6;
    @(negedge clk);
    queue_random(510);
    while (pending_reqs.size() != 0) @(negedge clk);
    @(posedge clk);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    @(negedge clk);
    queue_random(510);
    // sender keeps offering while the receiver holds off, so the block backs up
    @(posedge clk);
    hold_trig <= 1'b1;
    @(posedge clk);
    hold_trig <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (2 * DEPTH + 24) @(posedge clk);
    if (fail_count == 0) $display("PASS weighted_table_sampler");
    else $display("FAIL weighted_table_sampler");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL weighted_table_sampler");
    $finish;
  end

endmodule
